FILE: hdl/pcpb_pkg.sv
// ----------------------------------------------------------------------------
// pcpb_pkg
// Shared types and constants of the column-post sprite blitter.
// ----------------------------------------------------------------------------
package pcpb_pkg;

	localparam int MAX_TEX_DIM_DEF = 2048;
	localparam int PALETTE_ENTRIES = 256;
	localparam int TBL_AW          = $clog2(PALETTE_ENTRIES);

	localparam int CFG_W  = 12;   // widest configuration register
	localparam int CIDX_W = 3;
	localparam int COL_W  = 11;   // sprite column number
	localparam int POS_W  = 14;   // signed row / column sums after origin offsets
	localparam int PIX_W  = 22;   // pixel index
	localparam int RGB_W  = 24;

	localparam logic [7:0] END_MARK = 8'hff;
	localparam logic [7:0] OPAQUE   = 8'hff;

	typedef enum logic [1:0] {
		KIND_PAL  = 2'd0,
		KIND_XLAT = 2'd1,
		KIND_COL  = 2'd2,
		KIND_BYTE = 2'd3
	} kind_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_ORIGIN_X  = 3'd0,
		CFG_ORIGIN_Y  = 3'd1,
		CFG_TEX_W     = 3'd2,
		CFG_TEX_H     = 3'd3,
		CFG_PITCH     = 3'd4,
		CFG_XLAT_EN   = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_TOP  = 3'd1,
		PH_LEN  = 3'd2,
		PH_PAD  = 3'd3,
		PH_DATA = 3'd4,
		PH_TAIL = 3'd5
	} phase_t;

	// One stream byte after parsing and clipping
	typedef struct packed {
		logic             vis;       // visible data byte, produces a pixel
		logic [7:0]       pix_byte;
		logic [POS_W-1:0] row;       // non-negative whenever vis is set
		logic [POS_W-1:0] col;
	} hit_t;

endpackage

FILE: hdl/patch_column_post_blitter.sv
// ----------------------------------------------------------------------------
// patch_column_post_blitter
// Decodes a column-post sprite stream into clipped RGBA pixel writes.
// ----------------------------------------------------------------------------
//  port group   dir   beat content
//  s_*          in    tuser: kind; tdata: index, rgb, map, column, stream byte
//  m_*          out   tdata: pixel index, red, green, blue, alpha
//  cfg_*        in    register index and value, one write per cycle
//
//  One item per cycle unless the output stalls. A pixel reaches m_* through the
//  translation read, palette read and multiply, then index add and output register.
//  Reset restores the register defaults and idles the post parser; palette
//  and translation contents are undefined until loaded.
//  With m_tready low and a beat waiting, every stage holds and s_tready drops.
module patch_column_post_blitter #(
	parameter int MAX_TEX_DIM = pcpb_pkg::MAX_TEX_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] table_index, [31:8] rgb_value, [39:32] map_value,
	// [50:40] column_x, [58:51] data_byte
	input  logic [63:0]                     s_tdata,
	// [1:0] kind
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [21:0] pixel_index, [29:22] red, [37:30] green, [45:38] blue, [53:46] alpha
	output logic [55:0]                     m_tdata,
	input  logic                            cfg_we,
	input  logic [pcpb_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [pcpb_pkg::CFG_W-1:0]      cfg_data
);

	localparam int DIM_W  = $clog2(MAX_TEX_DIM + 1);
	localparam int ROW_W  = $clog2(MAX_TEX_DIM);
	localparam int PROD_W = ROW_W + DIM_W;
	localparam int AW     = pcpb_pkg::TBL_AW;
	localparam int PIX_W  = pcpb_pkg::PIX_W;
	localparam int CFG_W  = pcpb_pkg::CFG_W;

	// configuration
	logic signed [CFG_W-1:0] origin_x_q, origin_y_q;
	logic [CFG_W-1:0]        clip_width_q, clip_height_q, row_pitch_q;
	logic                    xlat_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			clip_width_q  <= CFG_W'(64);
			clip_height_q <= CFG_W'(64);
			row_pitch_q   <= CFG_W'(64);
			xlat_en_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcpb_pkg::CFG_ORIGIN_X: origin_x_q    <= cfg_data;
				pcpb_pkg::CFG_ORIGIN_Y: origin_y_q    <= cfg_data;
				pcpb_pkg::CFG_TEX_W:    clip_width_q  <= cfg_data;
				pcpb_pkg::CFG_TEX_H:    clip_height_q <= cfg_data;
				pcpb_pkg::CFG_PITCH:    row_pitch_q   <= cfg_data;
				pcpb_pkg::CFG_XLAT_EN:  xlat_en_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// input beat fields
	pcpb_pkg::kind_t                 in_kind;
	logic [AW-1:0]                   in_tidx;
	logic [pcpb_pkg::RGB_W-1:0]      in_rgb;
	logic [7:0]                      in_map;
	logic [pcpb_pkg::COL_W-1:0]      in_col;
	logic [7:0]                      in_byte;

	assign in_kind = pcpb_pkg::kind_t'(s_tuser);
	assign in_tidx = s_tdata[7:0];
	assign in_rgb  = s_tdata[31:8];
	assign in_map  = s_tdata[39:32];
	assign in_col  = s_tdata[50:40];
	assign in_byte = s_tdata[58:51];

	logic adv, accept;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	pcpb_pkg::hit_t hit;

	pcpb_post_parser #(
		.MAX_TEX_DIM (MAX_TEX_DIM)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (in_kind),
		.data_byte   (in_byte),
		.column_x    (in_col),
		.origin_x    (origin_x_q),
		.origin_y    (origin_y_q),
		.clip_width  (clip_width_q),
		.clip_height (clip_height_q),
		.hit         (hit)
	);

	// stage 1: translation table read
	logic [7:0]       xlat_mem [pcpb_pkg::PALETTE_ENTRIES];
	logic [7:0]       xlat_rd_s1;
	logic             vld_s1;
	logic [7:0]       byte_s1;
	logic [ROW_W-1:0] row_s1, col_s1;

	always_ff @(posedge clk) begin
		if (accept && in_kind == pcpb_pkg::KIND_XLAT) begin
			xlat_mem[in_tidx] <= in_map;
		end
		if (adv) begin
			xlat_rd_s1 <= xlat_mem[in_byte];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= hit.vis;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_s1 <= hit.pix_byte;
			row_s1  <= hit.row[ROW_W-1:0];
			col_s1  <= hit.col[ROW_W-1:0];
		end
	end

	// stage 2: palette read and row multiply
	logic [pcpb_pkg::RGB_W-1:0] pal_mem [pcpb_pkg::PALETTE_ENTRIES];
	logic [pcpb_pkg::RGB_W-1:0] pal_rd_s2;
	logic [AW-1:0]              pal_addr;
	logic [DIM_W-1:0]           pitch_sat;
	logic                       vld_s2;
	logic [PROD_W-1:0]          prod_s2;
	logic [ROW_W-1:0]           col_s2;

	assign pal_addr  = xlat_en_q ? xlat_rd_s1 : byte_s1;
	assign pitch_sat = (32'(row_pitch_q) > 32'(MAX_TEX_DIM)) ?
		DIM_W'(MAX_TEX_DIM) : DIM_W'(row_pitch_q);

	// a write here belongs to a later item than the read in the same cycle
	always_ff @(posedge clk) begin
		if (accept && in_kind == pcpb_pkg::KIND_PAL) begin
			pal_mem[in_tidx] <= in_rgb;
		end
		if (adv) begin
			pal_rd_s2 <= pal_mem[pal_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= PROD_W'(row_s1) * PROD_W'(pitch_sat);
			col_s2  <= col_s1;
		end
	end

	// output register
	logic [PIX_W-1:0] pix_idx;
	logic             m_tvalid_q;
	logic [55:0]      m_tdata_q;

	assign pix_idx = PIX_W'(prod_s2) + PIX_W'(col_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {2'b00, pcpb_pkg::OPAQUE, pal_rd_s2[7:0], pal_rd_s2[15:8],
				pal_rd_s2[23:16], pix_idx};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv |=> vld_s2)
		else $error("pixel lost between stage 1 and stage 2");

	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && adv |=> m_tvalid)
		else $error("pixel lost before output register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(vld_s2))
		else $error("pipeline moved while output stalled");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s2 && adv |=> !m_tvalid)
		else $error("output beat without a pixel behind it");

endmodule

FILE: hdl/pcpb_post_parser.sv
// ----------------------------------------------------------------------------
// pcpb_post_parser
// Walks the post structure of a sprite column and clips each data byte.
// ----------------------------------------------------------------------------
module pcpb_post_parser #(
	parameter int MAX_TEX_DIM = pcpb_pkg::MAX_TEX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  pcpb_pkg::kind_t               kind,
	input  logic [7:0]                    data_byte,
	input  logic [pcpb_pkg::COL_W-1:0]    column_x,
	input  logic signed [pcpb_pkg::CFG_W-1:0] origin_x,
	input  logic signed [pcpb_pkg::CFG_W-1:0] origin_y,
	input  logic [pcpb_pkg::CFG_W-1:0]    clip_width,
	input  logic [pcpb_pkg::CFG_W-1:0]    clip_height,
	output pcpb_pkg::hit_t                hit
);

	localparam int DIM_W = $clog2(MAX_TEX_DIM + 1);
	localparam int POS_W = pcpb_pkg::POS_W;
	localparam int CFG_W = pcpb_pkg::CFG_W;

	pcpb_pkg::phase_t               phase_q, phase_d;
	logic [7:0]                     top_q, top_d;
	logic [7:0]                     rem_q, rem_d;
	logic [7:0]                     off_q, off_d;
	logic [pcpb_pkg::COL_W-1:0]     column_q, column_d;

	logic [7:0]       rem_dec;
	logic [DIM_W-1:0] w_sat, h_sat;
	logic [POS_W-1:0] row_sum, col_sum;
	logic             row_ok, col_ok, is_data;

	assign rem_dec = rem_q - 8'd1;
	assign is_data = accept && (kind == pcpb_pkg::KIND_BYTE) && (phase_q == pcpb_pkg::PH_DATA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= pcpb_pkg::PH_IDLE;
			top_q    <= '0;
			rem_q    <= '0;
			off_q    <= '0;
			column_q <= '0;
		end else begin
			phase_q  <= phase_d;
			top_q    <= top_d;
			rem_q    <= rem_d;
			off_q    <= off_d;
			column_q <= column_d;
		end
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		top_d    = top_q;
		rem_d    = rem_q;
		off_d    = off_q;
		column_d = column_q;
		if (accept) begin
			unique case (kind)
				pcpb_pkg::KIND_PAL, pcpb_pkg::KIND_XLAT: begin
				end
				pcpb_pkg::KIND_COL: begin
					column_d = column_x;
					phase_d  = pcpb_pkg::PH_TOP;
					rem_d    = '0;
					off_d    = '0;
				end
				pcpb_pkg::KIND_BYTE: begin
					unique case (phase_q)
						pcpb_pkg::PH_TOP: begin
							if (data_byte == pcpb_pkg::END_MARK) begin
								phase_d = pcpb_pkg::PH_IDLE;
							end else begin
								top_d   = data_byte;
								phase_d = pcpb_pkg::PH_LEN;
							end
						end
						pcpb_pkg::PH_LEN: begin
							rem_d   = data_byte;
							off_d   = '0;
							phase_d = pcpb_pkg::PH_PAD;
						end
						pcpb_pkg::PH_PAD: begin
							phase_d = (rem_q == 8'd0) ? pcpb_pkg::PH_TAIL : pcpb_pkg::PH_DATA;
						end
						pcpb_pkg::PH_TAIL: begin
							phase_d = pcpb_pkg::PH_TOP;
						end
						pcpb_pkg::PH_DATA: begin
							off_d = off_q + 8'd1;
							rem_d = rem_dec;
							if (rem_dec == 8'd0) begin
								phase_d = pcpb_pkg::PH_TAIL;
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// clip against the saturated texture size
	always_comb begin
		w_sat = (32'(clip_width) > 32'(MAX_TEX_DIM)) ? DIM_W'(MAX_TEX_DIM) : DIM_W'(clip_width);
		h_sat = (32'(clip_height) > 32'(MAX_TEX_DIM)) ? DIM_W'(MAX_TEX_DIM) : DIM_W'(clip_height);
		row_sum = POS_W'(top_q) + POS_W'(off_q)
			+ {{(POS_W-CFG_W){origin_y[CFG_W-1]}}, origin_y};
		col_sum = POS_W'(column_q) + {{(POS_W-CFG_W){origin_x[CFG_W-1]}}, origin_x};
		row_ok  = !row_sum[POS_W-1] && (row_sum < POS_W'(h_sat));
		col_ok  = !col_sum[POS_W-1] && (col_sum < POS_W'(w_sat));
	end

	// outputs
	always_comb begin
		hit.vis      = is_data && row_ok && col_ok;
		hit.pix_byte = data_byte;
		hit.row      = row_sum;
		hit.col      = col_sum;
	end

	a_data_has_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == pcpb_pkg::PH_DATA |-> rem_q != 8'd0)
		else $error("data phase entered with no bytes left");

	a_hit_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		hit.vis |-> accept && phase_q == pcpb_pkg::PH_DATA)
		else $error("pixel raised outside data phase");

	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == pcpb_pkg::KIND_BYTE && phase_q == pcpb_pkg::PH_TOP
			&& data_byte == pcpb_pkg::END_MARK |=> phase_q == pcpb_pkg::PH_IDLE)
		else $error("end marker did not close the column");

endmodule
